// File: rtl/core/amge_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amge_pkg: shared types for the adjacency matrix graph editor
// Command and status codes, item structs and the job record that the
// classifier hands to the matrix engine.
// ----------------------------------------------------------------------------
package amge_pkg;

    localparam int AMGE_MAX_VERTICES = 32;
    localparam int AMGE_QUEUE_DEPTH  = 2;

    typedef enum logic [2:0] {
        CMD_CLEAR   = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_READ    = 3'd2,
        CMD_INS_VTX = 3'd3,
        CMD_INS_ARC = 3'd4,
        CMD_DEL_VTX = 3'd5,
        CMD_DEL_ARC = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // matrix work the engine carries out
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_WRITE,
        OP_READ,
        OP_INSERT,
        OP_DELETE,
        OP_ARC
    } t_op;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_ROW_A,
        BK_ROW_B,
        BK_SWEEP,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        logic [2:0] command;
        logic [5:0] first_vertex;
        logic [4:0] second_vertex;
        logic       entry_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic       read_bit;
        logic [5:0] vertex_count;
    } t_out_item;

    typedef struct packed {
        t_op        op;
        logic [5:0] v;
        logic [4:0] w;
        logic       bit_val;
        logic [5:0] sweep_top;    // highest row touched by insert/delete
        t_status    status;
        logic [5:0] count;        // vertex count after the item
    } t_job;

endpackage

// File: rtl/core/amge_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amge_front: command classifier
// Checks each item against the tracked vertex count, settles its status and
// new count at once, and pushes a job for the matrix engine.
// ----------------------------------------------------------------------------
module amge_front #(
    parameter int MAX_VERTICES = amge_pkg::AMGE_MAX_VERTICES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_full,
    input  amge_pkg::t_in_item i_item,
    output logic               o_push,
    output amge_pkg::t_job     o_job
);
    import amge_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [7:0]       v8;
    logic [7:0]       w8;
    logic [7:0]       n8;
    logic [7:0]       max8;
    logic             pair_ok;
    t_job             job;

    always_comb begin
        v8      = {2'b00, i_item.first_vertex};
        w8      = {3'b000, i_item.second_vertex};
        n8      = 8'(r_count);
        max8    = 8'(MAX_VERTICES);
        pair_ok = (v8 < n8) && (w8 < n8);
        n_count = r_count;

        job.op        = OP_NONE;
        job.v         = i_item.first_vertex;
        job.w         = i_item.second_vertex;
        job.bit_val   = i_item.entry_value;
        job.sweep_top = '0;
        job.status    = ST_DONE;

        unique case (i_item.command)
            CMD_CLEAR: begin
                if (v8 > max8) begin
                    job.status = ST_RANGE;
                end else begin
                    job.op  = OP_CLEAR;
                    n_count = CNT_W'(i_item.first_vertex);
                end
            end
            CMD_WRITE: begin
                if (pair_ok) job.op = OP_WRITE;
                else         job.status = ST_RANGE;
            end
            CMD_READ: begin
                if (pair_ok) job.op = OP_READ;
                else         job.status = ST_RANGE;
            end
            CMD_INS_ARC, CMD_DEL_ARC: begin
                job.bit_val = (i_item.command == CMD_INS_ARC);
                if (pair_ok) job.op = OP_ARC;
                else         job.status = ST_RANGE;
            end
            CMD_INS_VTX: begin
                if (n8 >= max8) begin
                    job.status = ST_FULL;
                end else if (v8 > n8) begin
                    job.status = ST_RANGE;
                end else begin
                    job.op        = OP_INSERT;
                    job.sweep_top = 6'(r_count);
                    n_count       = r_count + CNT_W'(1);
                end
            end
            CMD_DEL_VTX: begin
                if (n8 == 8'd0) begin
                    job.status = ST_EMPTY;
                end else if (v8 >= n8) begin
                    job.status = ST_RANGE;
                end else begin
                    job.op        = OP_DELETE;
                    job.sweep_top = 6'(r_count - CNT_W'(1));
                    n_count       = r_count - CNT_W'(1);
                end
            end
            default: begin
                job.status = ST_RANGE;
            end
        endcase

        job.count = 6'(n_count);
    end

    assign o_push = i_valid && !i_full;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/core/amge_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amge_queue: job queue
// Small FIFO between the classifier and the matrix engine.
// ----------------------------------------------------------------------------
module amge_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  amge_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output amge_pkg::t_job o_job
);
    import amge_pkg::*;

    localparam int PTR_W = $clog2(AMGE_QUEUE_DEPTH);
    localparam int CNT_W = $clog2(AMGE_QUEUE_DEPTH + 1);

    t_job             r_mem [AMGE_QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(AMGE_QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(AMGE_QUEUE_DEPTH - 1)) ? '0
                                                                      : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(AMGE_QUEUE_DEPTH - 1)) ? '0
                                                                      : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !do_pop)      r_cnt <= r_cnt + CNT_W'(1);
            else if (do_pop && !i_push) r_cnt <= r_cnt - CNT_W'(1);
        end
    end

endmodule

// File: rtl/core/amge_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amge_back: matrix engine
// Holds the adjacency rows in a single-port-read row memory with per-row
// valid bits, runs entry and arc read-modify-writes and the row sweeps of
// vertex insert and delete, and holds the result item for the output.
// ----------------------------------------------------------------------------
module amge_back #(
    parameter int MAX_VERTICES = amge_pkg::AMGE_MAX_VERTICES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  amge_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output amge_pkg::t_out_item o_item
);
    import amge_pkg::*;

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam logic [MAX_VERTICES-1:0] ROW_ONE = MAX_VERTICES'(1);

    t_back_state             r_state;
    t_back_state             n_state;
    t_job                    r_job;
    logic [MAX_VERTICES-1:0] r_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_row_vld;
    logic [MAX_VERTICES-1:0] r_rd_data;
    logic                    r_rd_ok;
    logic                    r_rbit;
    logic [IDX_W-1:0]        r_sw_idx;
    logic                    r_sw_more;
    logic                    r_pend;
    logic [IDX_W-1:0]        r_pend_dst;
    logic                    r_pend_zero;
    logic                    r_out_vld;
    t_out_item               r_out_item;

    logic                    take;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [MAX_VERTICES-1:0] wr_data;
    logic                    clr_all;
    logic [MAX_VERTICES-1:0] row;
    logic [MAX_VERTICES-1:0] row_mod;
    logic [MAX_VERTICES-1:0] row_shift;
    logic [MAX_VERTICES-1:0] lo_mask;
    logic [IDX_W-1:0]        v_idx;
    logic [IDX_W-1:0]        w_idx;
    logic [IDX_W-1:0]        top_idx;
    logic [IDX_W-1:0]        bit_idx;
    logic                    is_ins;
    logic [IDX_W-1:0]        sw_src;
    logic                    sw_zero;
    logic                    sw_last;

    assign v_idx   = IDX_W'(r_job.v);
    assign w_idx   = IDX_W'(r_job.w);
    assign top_idx = IDX_W'(r_job.sweep_top);
    assign is_ins  = (r_job.op == OP_INSERT);
    assign take    = i_q_valid && !r_out_vld;
    assign row     = r_rd_ok ? r_rd_data : '0;
    assign lo_mask = (ROW_ONE << v_idx) - ROW_ONE;

    // insert walks down from the top row, delete walks up from row 0
    always_comb begin
        if (is_ins) begin
            sw_zero = (r_sw_idx == v_idx);
            sw_src  = (r_sw_idx > v_idx) ? r_sw_idx - IDX_W'(1) : r_sw_idx;
            sw_last = (r_sw_idx == '0);
        end else begin
            sw_zero = (r_sw_idx == top_idx);
            sw_src  = (r_sw_idx >= v_idx && !sw_zero) ? r_sw_idx + IDX_W'(1) : r_sw_idx;
            sw_last = (r_sw_idx == top_idx);
        end
    end

    // open or close column v in the row just read
    always_comb begin
        if (is_ins) row_shift = (row & lo_mask) | ((row & ~lo_mask) << 1);
        else        row_shift = (row & lo_mask) | ((row >> 1) & ~lo_mask);
    end

    always_comb begin
        bit_idx          = (r_state == BK_ROW_B) ? v_idx : w_idx;
        row_mod          = row;
        row_mod[bit_idx] = r_job.bit_val;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (take) n_state = BK_EXEC;
            end
            BK_EXEC: begin
                unique case (r_job.op)
                    OP_NONE, OP_CLEAR:    n_state = BK_DONE;
                    OP_INSERT, OP_DELETE: n_state = BK_SWEEP;
                    default:              n_state = BK_ROW_A;
                endcase
            end
            BK_ROW_A: begin
                n_state = (r_job.op == OP_ARC) ? BK_ROW_B : BK_DONE;
            end
            BK_ROW_B: begin
                n_state = BK_DONE;
            end
            BK_SWEEP: begin
                if (!r_sw_more) n_state = BK_DONE;
            end
            BK_DONE: begin
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // memory port controls
    always_comb begin
        o_pop   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = v_idx;
        wr_en   = 1'b0;
        wr_addr = v_idx;
        wr_data = row_mod;
        clr_all = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                o_pop = take;
            end
            BK_EXEC: begin
                clr_all = (r_job.op == OP_CLEAR);
                rd_en   = (r_job.op == OP_READ) || (r_job.op == OP_WRITE)
                          || (r_job.op == OP_ARC);
            end
            BK_ROW_A: begin
                wr_en   = (r_job.op == OP_WRITE) || (r_job.op == OP_ARC);
                rd_en   = (r_job.op == OP_ARC);
                rd_addr = w_idx;
            end
            BK_ROW_B: begin
                wr_en   = 1'b1;
                wr_addr = w_idx;
            end
            BK_SWEEP: begin
                rd_en   = r_sw_more;
                rd_addr = sw_src;
                wr_en   = r_pend;
                wr_addr = r_pend_dst;
                wr_data = r_pend_zero ? '0 : row_shift;
            end
            BK_DONE: begin
                o_pop = 1'b0;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_ok   <= r_row_vld[rd_addr];
        end
        if (take && r_state == BK_IDLE) r_job <= i_job;
        if (r_state == BK_EXEC) begin
            r_rbit   <= 1'b0;
            r_sw_idx <= (r_job.op == OP_INSERT) ? top_idx : '0;
        end else if (r_state == BK_ROW_A && r_job.op == OP_READ) begin
            r_rbit <= row[w_idx];
        end else if (r_state == BK_SWEEP && r_sw_more) begin
            r_pend_dst  <= r_sw_idx;
            r_pend_zero <= sw_zero;
            r_sw_idx    <= is_ins ? r_sw_idx - IDX_W'(1) : r_sw_idx + IDX_W'(1);
        end
        if (r_state == BK_DONE) begin
            r_out_item.status       <= r_job.status;
            r_out_item.read_bit     <= r_rbit;
            r_out_item.vertex_count <= r_job.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_row_vld <= '0;
            r_sw_more <= 1'b0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clr_all) begin
                r_row_vld <= '0;
            end else if (wr_en) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
            if (r_state == BK_EXEC) begin
                r_sw_more <= 1'b1;
                r_pend    <= 1'b0;
            end else if (r_state == BK_SWEEP) begin
                r_pend <= r_sw_more;
                if (sw_last) r_sw_more <= 1'b0;
            end
            if (r_state == BK_DONE) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_out_item;

endmodule

// File: rtl/core/adjacency_matrix_graph_editor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_editor_top: undirected graph editor
//
//   channel   direction   handshake                    payload
//   in        input       i_in_valid / o_in_stall      i_in_item  (t_in_item)
//   out       output      o_out_valid / i_out_stall    o_out_item (t_out_item)
//
// A classifier settles status and count as an item arrives; a two-deep
// queue feeds the matrix engine, which works on one item at a time. Vertex
// insert and delete sweep the rows through the row memory, so they take
// longer the more vertices the graph holds.
// The matrix is empty after reset through per-row valid bits; no clearing pass.
// A result holds the engine until it is taken while the queue keeps taking items.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_editor_top #(
    parameter int MAX_VERTICES = amge_pkg::AMGE_MAX_VERTICES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  amge_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output amge_pkg::t_out_item o_out_item
);
    import amge_pkg::*;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_job push_job;
    t_job head_job;

    assign o_in_stall = q_full;

    amge_front #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_full  (q_full),
        .i_item  (i_in_item),
        .o_push  (q_push),
        .o_job   (push_job)
    );

    amge_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (head_job)
    );

    amge_back #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (head_job),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_item    (o_out_item)
    );

endmodule

// File: rtl/core/amge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amge_checker: port-level checks for the graph editor
// Watches the result channel for hold behavior and status consistency.
// ----------------------------------------------------------------------------
module amge_checker #(
    parameter int MAX_VERTICES = amge_pkg::AMGE_MAX_VERTICES
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input amge_pkg::t_out_item o_out_item
);
    import amge_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_rbit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_DONE |-> !o_out_item.read_bit)
        else $error("read bit set on a refused item");

    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_EMPTY |-> o_out_item.vertex_count == '0)
        else $error("empty status with vertices present");

    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_FULL
        |-> o_out_item.vertex_count == 6'(MAX_VERTICES))
        else $error("full status below capacity");

endmodule

bind adjacency_matrix_graph_editor_top amge_checker #(
    .MAX_VERTICES(MAX_VERTICES)
) u_amge_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the adjacency matrix graph editor
// A clocked driver takes edit commands from a backlog and works out each
// answer as the block accepts the command. A clocked monitor checks every
// result against the oldest answer still due. Both sides idle at random,
// and there is one long output hold and two drain pauses on the input.
// ----------------------------------------------------------------------------
module tb_top;
    import amge_pkg::*;

    localparam int MAXV        = AMGE_MAX_VERTICES;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 60;
    localparam int RANDOM_CMDS = 1330;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        t_in_item item;
        bit       after_drain;   // present only once every answer is back
    } t_backlog_entry;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_item  in_item    = '0;
    logic      out_stall  = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    adjacency_matrix_graph_editor_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    // graph as the block should hold it
    logic [31:0] graph_rows [MAXV];
    logic [5:0]  graph_count;

    t_backlog_entry cmd_backlog [$];
    t_out_item      answers_due [$];
    int             accepted_cnt;
    int             results_cnt = 0;
    int             error_cnt   = 0;
    int             idle_cycles = 0;
    int             gen_count   = 0;
    bit             hold_next   = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic graph_edit(input t_in_item it, output t_out_item ans);
        logic [5:0]  n;
        logic [5:0]  v;
        logic [4:0]  w;
        logic [31:0] lo;
        logic        pair_ok;
        logic        rb;
        t_status     st;
        int          i;
        begin
            n       = graph_count;
            v       = it.first_vertex;
            w       = it.second_vertex;
            pair_ok = (v < n) && ({1'b0, w} < n);
            st      = ST_DONE;
            rb      = 1'b0;
            case (it.command)
                CMD_CLEAR: begin
                    if (v > MAXV) begin
                        st = ST_RANGE;
                    end else begin
                        foreach (graph_rows[k]) graph_rows[k] = '0;
                        graph_count = v;
                    end
                end
                CMD_WRITE: begin
                    if (!pair_ok) st = ST_RANGE;
                    else graph_rows[v][w] = it.entry_value;
                end
                CMD_READ: begin
                    if (!pair_ok) st = ST_RANGE;
                    else rb = graph_rows[v][w];
                end
                CMD_INS_VTX: begin
                    if (n >= MAXV) begin
                        st = ST_FULL;
                    end else if (v > n) begin
                        st = ST_RANGE;
                    end else begin
                        for (i = n; i > v; i--) graph_rows[i] = graph_rows[i-1];
                        graph_rows[v] = '0;
                        lo = (32'd1 << v) - 32'd1;
                        for (i = 0; i <= n; i++)
                            graph_rows[i] = (graph_rows[i] & lo) | ((graph_rows[i] & ~lo) << 1);
                        graph_count = n + 6'd1;
                    end
                end
                CMD_INS_ARC, CMD_DEL_ARC: begin
                    if (!pair_ok) begin
                        st = ST_RANGE;
                    end else begin
                        graph_rows[v][w] = (it.command == CMD_INS_ARC);
                        graph_rows[w][v] = (it.command == CMD_INS_ARC);
                    end
                end
                CMD_DEL_VTX: begin
                    if (n == 0) begin
                        st = ST_EMPTY;
                    end else if (v >= n) begin
                        st = ST_RANGE;
                    end else begin
                        for (i = v; i + 1 < n; i++) graph_rows[i] = graph_rows[i+1];
                        graph_rows[n-1] = '0;
                        lo = (32'd1 << v) - 32'd1;
                        for (i = 0; i < n; i++)
                            graph_rows[i] = (graph_rows[i] & lo) | ((graph_rows[i] >> 1) & ~lo);
                        graph_count = n - 6'd1;
                    end
                end
                default: st = ST_RANGE;
            endcase
            ans.status       = st;
            ans.read_bit     = rb;
            ans.vertex_count = graph_count;
        end
    endtask

    // queue a command; a rough count is kept so random indices mostly land in range
    task automatic queue_cmd(input logic [2:0] c, input logic [5:0] v,
                             input logic [4:0] w, input logic b);
        t_backlog_entry e;
        begin
            e.item.command       = c;
            e.item.first_vertex  = v;
            e.item.second_vertex = w;
            e.item.entry_value   = b;
            e.after_drain        = hold_next;
            hold_next            = 1'b0;
            cmd_backlog.push_back(e);
            if (c == CMD_CLEAR && v <= MAXV) gen_count = v;
            else if (c == CMD_INS_VTX && gen_count < MAXV && v <= gen_count) gen_count++;
            else if (c == CMD_DEL_VTX && gen_count > 0 && v < gen_count) gen_count--;
        end
    endtask

    function automatic logic [5:0] pick_vertex(input int lim);
        if (lim == 0 || $urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, lim - 1));
    endfunction

    // driver
    always @(posedge i_clk) begin : drive_cmds
        bit             took;
        bit             brisk;
        int             gap_left;
        t_out_item      ans;
        t_backlog_entry nxt;
        if (!i_rst_n) begin
            in_valid     <= 1'b0;
            in_item      <= '0;
            gap_left     = 0;
            accepted_cnt = 0;
            foreach (graph_rows[k]) graph_rows[k] = '0;
            graph_count  = '0;
        end else begin
            took = in_valid && !o_in_stall;
            if (took) begin
                graph_edit(in_item, ans);
                answers_due.push_back(ans);
                accepted_cnt++;
                brisk    = ((accepted_cnt / 128) % 4) >= 2;
                gap_left = brisk ? 0 : $urandom_range(0, 7);
            end
            if (in_valid && !took) begin
                // hold the stalled item
            end else if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (cmd_backlog.size() > 0 &&
                         !(cmd_backlog[0].after_drain && results_cnt != accepted_cnt)) begin
                nxt = cmd_backlog.pop_front();
                in_item  <= nxt.item;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : check_results
        bit        got;
        bit        brisk;
        int        stall_left;
        int        hold_left;
        t_out_item want;
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            got = o_out_valid && !out_stall;
            if (got) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual status %0d bit %0d count %0d",
                             $time, o_out_item.status, o_out_item.read_bit,
                             o_out_item.vertex_count);
                    error_cnt++;
                end else begin
                    want = answers_due.pop_front();
                    if (o_out_item.status !== want.status ||
                        o_out_item.read_bit !== want.read_bit ||
                        o_out_item.vertex_count !== want.vertex_count) begin
                        $display("%0t: mismatch: expected status %0d bit %0d count %0d, actual status %0d bit %0d count %0d",
                                 $time, want.status, want.read_bit, want.vertex_count,
                                 o_out_item.status, o_out_item.read_bit,
                                 o_out_item.vertex_count);
                        error_cnt++;
                    end
                end
                results_cnt <= results_cnt + 1;
                brisk      = ((results_cnt / 128) % 4) == 3;
                stall_left = brisk ? 0 : $urandom_range(0, 7);
                // long hold so the input side backs up
                if (results_cnt == 450) hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int         k;
        int         pick;
        int         r;
        logic [5:0] v;
        logic [4:0] w;

        // directed: refusals on empty, full and out-of-range, diagonal arcs,
        // one-sided writes, append, shifting rows, unused command
        queue_cmd(CMD_READ,    6'd0,  5'd0,  1'b0);
        queue_cmd(CMD_DEL_VTX, 6'd0,  5'd0,  1'b1);
        queue_cmd(CMD_INS_VTX, 6'd1,  5'd0,  1'b0);
        queue_cmd(CMD_INS_VTX, 6'd0,  5'd0,  1'b0);
        queue_cmd(CMD_INS_ARC, 6'd0,  5'd0,  1'b1);
        queue_cmd(CMD_CLEAR,   6'd33, 5'd0,  1'b0);
        queue_cmd(CMD_CLEAR,   6'd63, 5'd31, 1'b1);
        queue_cmd(CMD_CLEAR,   6'd32, 5'd0,  1'b0);
        queue_cmd(CMD_INS_ARC, 6'd31, 5'd31, 1'b0);
        queue_cmd(CMD_INS_ARC, 6'd0,  5'd31, 1'b1);
        queue_cmd(CMD_WRITE,   6'd5,  5'd3,  1'b1);
        queue_cmd(CMD_READ,    6'd3,  5'd5,  1'b0);
        queue_cmd(CMD_READ,    6'd5,  5'd3,  1'b1);
        queue_cmd(CMD_INS_VTX, 6'd40, 5'd0,  1'b0);
        queue_cmd(CMD_WRITE,   6'd31, 5'd31, 1'b0);
        queue_cmd(CMD_DEL_VTX, 6'd32, 5'd0,  1'b0);
        queue_cmd(CMD_DEL_VTX, 6'd0,  5'd0,  1'b0);
        queue_cmd(CMD_READ,    6'd30, 5'd0,  1'b0);
        queue_cmd(CMD_WRITE,   6'd31, 5'd0,  1'b1);
        queue_cmd(CMD_INS_VTX, 6'd31, 5'd0,  1'b1);
        queue_cmd(CMD_READ,    6'd30, 5'd30, 1'b0);
        queue_cmd(CMD_DEL_ARC, 6'd30, 5'd4,  1'b0);
        queue_cmd(CMD_UNUSED,  6'd12, 5'd7,  1'b1);
        queue_cmd(CMD_CLEAR,   6'd0,  5'd0,  1'b0);

        for (k = 0; k < RANDOM_CMDS; k++) begin
            if (k == 0 || k == 700) hold_next = 1'b1;
            pick = $urandom_range(0, 99);
            if (gen_count > 0 && $urandom_range(0, 9) != 0)
                w = 5'($urandom_range(0, gen_count - 1));
            else
                w = 5'($urandom_range(0, 31));
            if (pick < 4) begin
                r = $urandom_range(0, 9);
                if (r < 6)      v = 6'($urandom_range(0, 12));
                else if (r < 8) v = 6'($urandom_range(13, 32));
                else if (r < 9) v = 6'($urandom_range(31, 32));
                else            v = 6'($urandom_range(0, 63));
                queue_cmd(CMD_CLEAR, v, w, 1'($urandom));
            end else if (pick < 18) begin
                queue_cmd(CMD_WRITE, pick_vertex(gen_count), w, 1'($urandom));
            end else if (pick < 42) begin
                queue_cmd(CMD_READ, pick_vertex(gen_count), w, 1'($urandom));
            end else if (pick < 58) begin
                queue_cmd(CMD_INS_VTX, pick_vertex(gen_count + 1), w, 1'($urandom));
            end else if (pick < 72) begin
                queue_cmd(CMD_INS_ARC, pick_vertex(gen_count), w, 1'($urandom));
            end else if (pick < 84) begin
                queue_cmd(CMD_DEL_VTX, pick_vertex(gen_count), w, 1'($urandom));
            end else if (pick < 97) begin
                queue_cmd(CMD_DEL_ARC, pick_vertex(gen_count), w, 1'($urandom));
            end else begin
                queue_cmd(CMD_UNUSED, 6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)),
                          1'($urandom));
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (cmd_backlog.size() != 0 || in_valid || results_cnt != accepted_cnt)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (answers_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, answers_due.size());
            error_cnt++;
        end
        if (error_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/amge_pkg.sv
rtl/core/amge_front.sv
rtl/core/amge_queue.sv
rtl/core/amge_back.sv
rtl/core/adjacency_matrix_graph_editor_top.sv
rtl/core/amge_checker.sv
test/tb_top.sv
